### hdl/cps_pkg.sv
// Package for clamp_point_to_disc: field widths, pipeline depth, register indexes
// and the structs that travel along the cell chains. No dependencies.
package cps_pkg;

   localparam int COORD_W    = 24;
   localparam int RAD_W      = 23;
   localparam int DIFF_W     = COORD_W + 1;
   localparam int MAG_W      = COORD_W;
   localparam int SQ_W       = 2 * MAG_W;
   localparam int DSQ_W      = SQ_W + 1;
   localparam int SQRT_STEPS = (DSQ_W + 1) / 2;
   localparam int N_W        = 2 * SQRT_STEPS;
   localparam int ROOT_W     = SQRT_STEPS;
   localparam int REM_W      = ROOT_W + 2;
   localparam int NUM_W      = MAG_W + RAD_W;
   localparam int DIV_STEPS  = RAD_W;
   localparam int DREM_W     = ROOT_W;
   localparam int PIPE_DEPTH = 3 + SQRT_STEPS + DIV_STEPS + 1;
   localparam int CSR_IDX_W  = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CENTER_X = 2'd0,
      CSR_CENTER_Z = 2'd1,
      CSR_RADIUS   = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic                      over;
      logic                      sign_x;
      logic                      sign_z;
      logic signed [COORD_W-1:0] pos_x;
      logic signed [COORD_W-1:0] pos_z;
      logic signed [COORD_W-1:0] center_x;
      logic signed [COORD_W-1:0] center_z;
   } side_type;

   typedef struct packed {
      logic [NUM_W-1:0] num_x;
      logic [NUM_W-1:0] num_z;
   } num_pair_type;

   typedef struct packed {
      logic [DREM_W-1:0] rem;
      logic [RAD_W-1:0]  lo;
   } div_axis_type;

endpackage

### hdl/cps_sqrt_cell.sv
// One step of the digit-by-digit integer square root: one result bit per cell.
// Depends on cps_pkg.
module cps_sqrt_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  cps_pkg::side_type           in_side,
   input  cps_pkg::num_pair_type       in_num,
   input  logic [cps_pkg::N_W-1:0]     in_n,
   input  logic [cps_pkg::REM_W-1:0]   in_rem,
   input  logic [cps_pkg::ROOT_W-1:0]  in_root,
   output logic                        out_valid,
   output cps_pkg::side_type           out_side,
   output cps_pkg::num_pair_type       out_num,
   output logic [cps_pkg::N_W-1:0]     out_n,
   output logic [cps_pkg::REM_W-1:0]   out_rem,
   output logic [cps_pkg::ROOT_W-1:0]  out_root
);
   import cps_pkg::*;

   logic [REM_W+1:0]  part;
   logic [REM_W+1:0]  trial;
   logic              take;
   logic              valid_ff;
   side_type          side_ff;
   num_pair_type      num_ff;
   logic [N_W-1:0]    n_ff,    n_in;
   logic [REM_W-1:0]  rem_ff,  rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;

   always_comb begin
      part    = {in_rem, in_n[N_W-1 -: 2]};
      trial   = {2'b00, in_root, 2'b01};
      take    = (part >= trial);
      n_in    = {in_n[N_W-3:0], 2'b00};
      rem_in  = take ? REM_W'(part - trial) : part[REM_W-1:0];
      root_in = {in_root[ROOT_W-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      side_ff <= in_side;
      num_ff  <= in_num;
      n_ff    <= n_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign out_valid = valid_ff;
   assign out_side  = side_ff;
   assign out_num   = num_ff;
   assign out_n     = n_ff;
   assign out_rem   = rem_ff;
   assign out_root  = root_ff;

endmodule

### hdl/cps_div_cell.sv
// One step of restoring division for both axes: one quotient bit per axis per cell.
// Depends on cps_pkg.
module cps_div_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  cps_pkg::side_type           in_side,
   input  logic [cps_pkg::ROOT_W-1:0]  in_dist,
   input  cps_pkg::div_axis_type       in_x,
   input  cps_pkg::div_axis_type       in_z,
   output logic                        out_valid,
   output cps_pkg::side_type           out_side,
   output logic [cps_pkg::ROOT_W-1:0]  out_dist,
   output cps_pkg::div_axis_type       out_x,
   output cps_pkg::div_axis_type       out_z
);
   import cps_pkg::*;

   logic [DREM_W:0]   part_x, part_z;
   logic              take_x, take_z;
   logic              valid_ff;
   side_type          side_ff;
   logic [ROOT_W-1:0] dist_ff;
   div_axis_type      x_ff, x_in, z_ff, z_in;

   always_comb begin
      part_x   = {in_x.rem, in_x.lo[RAD_W-1]};
      part_z   = {in_z.rem, in_z.lo[RAD_W-1]};
      take_x   = (part_x >= {1'b0, in_dist});
      take_z   = (part_z >= {1'b0, in_dist});
      x_in.rem = take_x ? DREM_W'(part_x - {1'b0, in_dist}) : part_x[DREM_W-1:0];
      z_in.rem = take_z ? DREM_W'(part_z - {1'b0, in_dist}) : part_z[DREM_W-1:0];
      x_in.lo  = {in_x.lo[RAD_W-2:0], take_x};
      z_in.lo  = {in_z.lo[RAD_W-2:0], take_z};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      side_ff <= in_side;
      dist_ff <= in_dist;
      x_ff    <= x_in;
      z_ff    <= z_in;
   end

   assign out_valid = valid_ff;
   assign out_side  = side_ff;
   assign out_dist  = dist_ff;
   assign out_x     = x_ff;
   assign out_z     = z_ff;

endmodule

### hdl/clamp_point_to_disc.sv
// Top level of clamp_point_to_disc: offset, square and sum stages, square root chain,
// divider chain and the rim/saturation stage. Depends on cps_pkg and both cells.
//
//   Channel  Handshake                Payload
//   req      start high, busy low     req_pos_x, req_pos_z
//   rsp      rsp_strobe, one cycle    rsp_out_x, rsp_out_z, rsp_moved
//   csr      csr_write_en             csr_index, csr_wdata
//
// One item is taken every cycle; busy stays low.
// Between taking an item and its result lie three entry stages,
// 25 square root cells, 23 divider cells and the output register.
// Reset clears the configuration registers and all valid bits.
// The receiver cannot stall, so no item is ever held back.
module clamp_point_to_disc (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic signed [cps_pkg::COORD_W-1:0]    req_pos_x,
   input  logic signed [cps_pkg::COORD_W-1:0]    req_pos_z,
   output logic                                  rsp_strobe,
   output logic signed [cps_pkg::COORD_W-1:0]    rsp_out_x,
   output logic signed [cps_pkg::COORD_W-1:0]    rsp_out_z,
   output logic                                  rsp_moved,
   input  logic                                  csr_write_en,
   input  logic [cps_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [cps_pkg::COORD_W-1:0]           csr_wdata
);
   import cps_pkg::*;

   localparam logic signed [COORD_W+1:0] SAT_MAX = (COORD_W+2)'(2**(COORD_W-1) - 1);
   localparam logic signed [COORD_W+1:0] SAT_MIN = -(COORD_W+2)'(2**(COORD_W-1));

   logic signed [COORD_W-1:0] center_x_ff, center_z_ff;
   logic [RAD_W-1:0]          radius_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= '0;
         center_z_ff <= '0;
         radius_ff   <= '0;
      end else if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_CENTER_X: center_x_ff <= csr_wdata;
            CSR_CENTER_Z: center_z_ff <= csr_wdata;
            CSR_RADIUS:   radius_ff   <= csr_wdata[RAD_W-1:0];
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   // Entry stage: offsets from the center.
   logic                     v0_ff;
   side_type                 s0_ff;
   logic signed [DIFF_W-1:0] dx_ff, dz_ff;
   logic [RAD_W-1:0]         rad0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else begin
         v0_ff <= start;
      end
      s0_ff.over     <= 1'b0;
      s0_ff.sign_x   <= 1'b0;
      s0_ff.sign_z   <= 1'b0;
      s0_ff.pos_x    <= req_pos_x;
      s0_ff.pos_z    <= req_pos_z;
      s0_ff.center_x <= center_x_ff;
      s0_ff.center_z <= center_z_ff;
      dx_ff   <= DIFF_W'(req_pos_x) - DIFF_W'(center_x_ff);
      dz_ff   <= DIFF_W'(req_pos_z) - DIFF_W'(center_z_ff);
      rad0_ff <= radius_ff;
   end

   // Square stage: magnitudes, squares and the numerators for the divider.
   logic [MAG_W-1:0]   ax, az;
   logic               v1_ff;
   side_type           s1_ff;
   logic [SQ_W-1:0]    sqx_ff, sqz_ff;
   logic [2*RAD_W-1:0] rsq_ff;
   num_pair_type       num1_ff;

   assign ax = dx_ff[DIFF_W-1] ? MAG_W'(-dx_ff) : MAG_W'(dx_ff);
   assign az = dz_ff[DIFF_W-1] ? MAG_W'(-dz_ff) : MAG_W'(dz_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= v0_ff;
      end
      s1_ff.over     <= s0_ff.over;
      s1_ff.sign_x   <= dx_ff[DIFF_W-1];
      s1_ff.sign_z   <= dz_ff[DIFF_W-1];
      s1_ff.pos_x    <= s0_ff.pos_x;
      s1_ff.pos_z    <= s0_ff.pos_z;
      s1_ff.center_x <= s0_ff.center_x;
      s1_ff.center_z <= s0_ff.center_z;
      sqx_ff       <= ax * ax;
      sqz_ff       <= az * az;
      rsq_ff       <= rad0_ff * rad0_ff;
      num1_ff.num_x <= ax * rad0_ff;
      num1_ff.num_z <= az * rad0_ff;
   end

   // Sum stage: squared distance and the outside test.
   logic [DSQ_W-1:0] dsq;
   logic             v2_ff;
   side_type         s2_ff;
   num_pair_type     num2_ff;
   logic [N_W-1:0]   n2_ff;

   assign dsq = DSQ_W'(sqx_ff) + DSQ_W'(sqz_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      s2_ff.over     <= (dsq > DSQ_W'(rsq_ff));
      s2_ff.sign_x   <= s1_ff.sign_x;
      s2_ff.sign_z   <= s1_ff.sign_z;
      s2_ff.pos_x    <= s1_ff.pos_x;
      s2_ff.pos_z    <= s1_ff.pos_z;
      s2_ff.center_x <= s1_ff.center_x;
      s2_ff.center_z <= s1_ff.center_z;
      num2_ff    <= num1_ff;
      n2_ff      <= N_W'(dsq);
   end

   // Square root chain.
   logic              sq_v    [SQRT_STEPS+1];
   side_type          sq_side [SQRT_STEPS+1];
   num_pair_type      sq_num  [SQRT_STEPS+1];
   logic [N_W-1:0]    sq_n    [SQRT_STEPS+1];
   logic [REM_W-1:0]  sq_rem  [SQRT_STEPS+1];
   logic [ROOT_W-1:0] sq_root [SQRT_STEPS+1];

   assign sq_v[0]    = v2_ff;
   assign sq_side[0] = s2_ff;
   assign sq_num[0]  = num2_ff;
   assign sq_n[0]    = n2_ff;
   assign sq_rem[0]  = '0;
   assign sq_root[0] = '0;

   for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
      cps_sqrt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (sq_v[i]),
         .in_side   (sq_side[i]),
         .in_num    (sq_num[i]),
         .in_n      (sq_n[i]),
         .in_rem    (sq_rem[i]),
         .in_root   (sq_root[i]),
         .out_valid (sq_v[i+1]),
         .out_side  (sq_side[i+1]),
         .out_num   (sq_num[i+1]),
         .out_n     (sq_n[i+1]),
         .out_rem   (sq_rem[i+1]),
         .out_root  (sq_root[i+1])
      );
   end

   // Divider chain: quotient magnitude times radius over distance, per axis.
   logic              dv_v    [DIV_STEPS+1];
   side_type          dv_side [DIV_STEPS+1];
   logic [ROOT_W-1:0] dv_dist [DIV_STEPS+1];
   div_axis_type      dv_x    [DIV_STEPS+1];
   div_axis_type      dv_z    [DIV_STEPS+1];

   assign dv_v[0]      = sq_v[SQRT_STEPS];
   assign dv_side[0]   = sq_side[SQRT_STEPS];
   assign dv_dist[0]   = sq_root[SQRT_STEPS];
   assign dv_x[0].rem  = DREM_W'(sq_num[SQRT_STEPS].num_x[NUM_W-1:RAD_W]);
   assign dv_x[0].lo   = sq_num[SQRT_STEPS].num_x[RAD_W-1:0];
   assign dv_z[0].rem  = DREM_W'(sq_num[SQRT_STEPS].num_z[NUM_W-1:RAD_W]);
   assign dv_z[0].lo   = sq_num[SQRT_STEPS].num_z[RAD_W-1:0];

   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
      cps_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (dv_v[j]),
         .in_side   (dv_side[j]),
         .in_dist   (dv_dist[j]),
         .in_x      (dv_x[j]),
         .in_z      (dv_z[j]),
         .out_valid (dv_v[j+1]),
         .out_side  (dv_side[j+1]),
         .out_dist  (dv_dist[j+1]),
         .out_x     (dv_x[j+1]),
         .out_z     (dv_z[j+1])
      );
   end

   // Rim stage: signed offset plus center, saturated; an unmoved point passes through.
   side_type                  fs;
   logic signed [COORD_W+1:0] qx, qz, sum_x, sum_z;
   logic signed [COORD_W-1:0] rim_x, rim_z;
   logic                      move;
   logic                      strobe_ff;
   logic signed [COORD_W-1:0] out_x_ff, out_z_ff;
   logic                      moved_ff;

   always_comb begin
      fs    = dv_side[DIV_STEPS];
      qx    = (COORD_W+2)'(dv_x[DIV_STEPS].lo);
      qz    = (COORD_W+2)'(dv_z[DIV_STEPS].lo);
      sum_x = (COORD_W+2)'(fs.center_x) + (fs.sign_x ? -qx : qx);
      sum_z = (COORD_W+2)'(fs.center_z) + (fs.sign_z ? -qz : qz);
      rim_x = (sum_x > SAT_MAX) ? SAT_MAX[COORD_W-1:0] :
              (sum_x < SAT_MIN) ? SAT_MIN[COORD_W-1:0] : sum_x[COORD_W-1:0];
      rim_z = (sum_z > SAT_MAX) ? SAT_MAX[COORD_W-1:0] :
              (sum_z < SAT_MIN) ? SAT_MIN[COORD_W-1:0] : sum_z[COORD_W-1:0];
      move  = fs.over && (dv_dist[DIV_STEPS] != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= dv_v[DIV_STEPS];
      end
      out_x_ff <= move ? rim_x : fs.pos_x;
      out_z_ff <= move ? rim_z : fs.pos_z;
      moved_ff <= move;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_out_x  = out_x_ff;
   assign rsp_out_z  = out_z_ff;
   assign rsp_moved  = moved_ff;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      start |-> ##PIPE_DEPTH rsp_strobe)
      else $error("item did not leave after the pipeline depth");

   a_pass_x: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_moved && $past(start, PIPE_DEPTH))
         |-> (rsp_out_x == $past(req_pos_x, PIPE_DEPTH)))
      else $error("unmoved point changed its x coordinate");

   a_pass_z: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_moved && $past(start, PIPE_DEPTH))
         |-> (rsp_out_z == $past(req_pos_z, PIPE_DEPTH)))
      else $error("unmoved point changed its z coordinate");

   a_zero_radius: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_moved && (radius_ff == '0))
         |-> (rsp_out_x == center_x_ff && rsp_out_z == center_z_ff))
      else $error("point not moved to the center for a zero radius");

endmodule
